// File: rtl/core/assert_macros.svh
// Assertion macros used by the port level checker of the dust meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLKD(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_CLK(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dpom_pkg.sv
// Types, constants and helper functions shared by the dust meter modules.
package dpom_pkg;

  localparam int LOW_W   = 32;  // low time and window counters
  localparam int WIN_W   = 32;  // window length register
  localparam int DIVR_W  = 24;  // ratio divisor register
  localparam int CONC_W  = 24;  // concentration, Q16.8
  localparam int RATIO_W = 24;  // occupancy ratio, Q8.16
  localparam int FRAC_W  = 16;  // fraction bits of the ratio

  localparam int NUM_W = 48;    // divider numerator
  localparam int DEN_W = 24;    // divider denominator

  localparam int R2_W  = 32;    // r squared, Q.16
  localparam int R3_W  = 40;    // r cubed, Q.16
  localparam int POS_W = 45;    // positive polynomial terms
  localparam int NEG_W = 38;    // negative polynomial term

  localparam int M_DATA_W = 56; // concentration and low time, whole bytes
  localparam int S_DATA_W = 8;  // pin level padded to one byte
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_DIVISOR = 8'd1;

  localparam logic [WIN_W-1:0]  WINDOW_TICKS_RESET  = 32'd5000000;
  localparam logic [DIVR_W-1:0] RATIO_DIVISOR_RESET = 24'd300000;

  // Polynomial coefficients in units of 1/(10 * 65536).
  localparam logic [POS_W-1:0] COEF_CUBE   = 45'd11;
  localparam logic [POS_W-1:0] COEF_LINEAR = 45'd5200;
  localparam logic [POS_W-1:0] OFFSET_TERM = 45'd406323;
  localparam logic [NEG_W-1:0] COEF_SQUARE = 38'd38;

  // 51200 = 2^11 * 25: a shift, then a division by 25 done as a multiplication by
  // ceil(2^34 / 25) and a shift by 34. Shifted sums of 25 * 2^24 or more saturate, and
  // below that they fit in 29 bits, where the reciprocal is exact.
  localparam int SCALE_SHIFT = 11;
  localparam int SCALED_W    = 29;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0]             SCALE_RECIP = 30'd687194768;
  localparam logic [POS_W-SCALE_SHIFT-1:0]   SCALE_SAT   = 34'd419430400;

  typedef struct packed {
    logic             valid;
    logic [LOW_W-1:0] low_count;
  } win_push_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RATIO,
    BK_SQUARE,
    BK_CUBE,
    BK_TERMS,
    BK_CLAMP,
    BK_SCALE,
    BK_EMIT
  } back_state_t;

  // Saturate a divider quotient to 24 bits.
  function automatic logic [CONC_W-1:0] sat24(input logic [NUM_W-1:0] q);
    sat24 = (q[NUM_W-1:CONC_W] != '0) ? {CONC_W{1'b1}} : q[CONC_W-1:0];
  endfunction

endpackage

// File: rtl/core/dpom_front.sv
// Front end: edge detection, low time counting and window timing per sample.
module dpom_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  input  logic                       pin_level,
  input  logic [dpom_pkg::WIN_W-1:0] window_ticks,
  input  logic                       q_full,
  output logic                       sample_ready,
  output dpom_pkg::win_push_t        push
);
  import dpom_pkg::*;

  logic             previous_level;
  logic             timing_active;
  logic             timing_active_next;
  logic [LOW_W-1:0] low_count;
  logic [LOW_W-1:0] low_count_next;
  logic [LOW_W-1:0] window_elapsed;
  logic [LOW_W-1:0] window_elapsed_next;
  logic [WIN_W-1:0] limit;
  logic             window_end;
  logic             accept;

  always_comb begin
    priority if (previous_level && !pin_level) begin
      timing_active_next = 1'b1;
    end else if (!previous_level && pin_level) begin
      timing_active_next = 1'b0;
    end else begin
      timing_active_next = timing_active;
    end
    low_count_next = (timing_active_next && low_count != '1) ? low_count + 1'b1 : low_count;
    window_elapsed_next = (window_elapsed != '1) ? window_elapsed + 1'b1 : window_elapsed;
    // A zero window length acts as one tick.
    limit = (window_ticks == '0) ? WIN_W'(1) : window_ticks;
    window_end = window_elapsed_next >= limit;
  end

  assign sample_ready   = !q_full;
  assign accept         = sample_valid && !q_full;
  assign push.valid     = accept && window_end;
  assign push.low_count = low_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b1;
      timing_active  <= 1'b0;
      low_count      <= '0;
      window_elapsed <= '0;
    end else if (accept) begin
      previous_level <= pin_level;
      timing_active  <= timing_active_next;
      if (window_end) begin
        low_count      <= '0;
        window_elapsed <= '0;
      end else begin
        low_count      <= low_count_next;
        window_elapsed <= window_elapsed_next;
      end
    end
  end

endmodule

// File: rtl/core/dpom_queue.sv
// Short FIFO of finished window low counts between front and back.
module dpom_queue #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dpom_pkg::win_push_t        push,
  input  logic                       pop,
  output logic                       full,
  output logic                       empty,
  output logic [dpom_pkg::LOW_W-1:0] head
);
  import dpom_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [LOW_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign head    = slots[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.low_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/dpom_div.sv
// Restoring divider, one quotient bit per cycle, used by the back end.
module dpom_div (
  input  logic               clk,
  input  logic               rst,
  input  dpom_pkg::div_req_t req,
  output dpom_pkg::div_rsp_t rsp
);
  import dpom_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] quot;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem, quot[NUM_W-1]};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.numer;
      rem  <= '0;
      den  <= req.denom;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && count == CNT_W'(NUM_W - 1);
      if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// File: rtl/core/dpom_back.sv
// Back end: ratio, polynomial and scaling of one window, then the output register.
module dpom_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dpom_pkg::DIVR_W-1:0] ratio_divisor,
  input  logic                        q_empty,
  input  logic [dpom_pkg::LOW_W-1:0]  q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dpom_pkg::CONC_W-1:0] out_conc,
  output logic [dpom_pkg::LOW_W-1:0]  out_low
);
  import dpom_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               load_out;

  logic [LOW_W-1:0]   low_time;
  logic [RATIO_W-1:0] ratio;
  logic [R2_W-1:0]    r2;
  logic [R3_W-1:0]    r3;
  logic [POS_W-1:0]   pos_sum;
  logic [NEG_W-1:0]   neg_sum;
  logic [CONC_W-1:0]  conc;
  logic [SCALED_W-1:0] scaled;
  logic                scale_sat;

  logic [2*RATIO_W-1:0]        square;
  logic [R2_W+RATIO_W-1:0]     cube;
  logic [POS_W-1:0]            diff;
  logic [SCALED_W+RECIP_W-1:0] scale_prod;

  dpom_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    square = ratio * ratio;
    cube   = r2 * ratio;
    // Negative sums clamp to zero.
    diff   = (pos_sum > POS_W'(neg_sum)) ? pos_sum - POS_W'(neg_sum) : '0;
    // Division by 25 through the reciprocal.
    scale_prod = scaled * SCALE_RECIP;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    div_req    = '0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          div_req.start = 1'b1;
          div_req.numer = {q_head, {FRAC_W{1'b0}}};
          div_req.denom = (ratio_divisor == '0) ? DEN_W'(1) : ratio_divisor;
          state_next    = BK_RATIO;
        end
      end
      BK_RATIO: begin
        if (div_rsp.done) begin
          state_next = BK_SQUARE;
        end
      end
      BK_SQUARE: state_next = BK_CUBE;
      BK_CUBE:   state_next = BK_TERMS;
      BK_TERMS:  state_next = BK_CLAMP;
      BK_CLAMP:  state_next = BK_SCALE;
      BK_SCALE:  state_next = BK_EMIT;
      BK_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      low_time <= q_head;
    end
    if (state == BK_RATIO && div_rsp.done) begin
      ratio <= sat24(div_rsp.quot);
    end
    if (state == BK_SQUARE) begin
      r2 <= square[2*RATIO_W-1:FRAC_W];
    end
    if (state == BK_CUBE) begin
      r3 <= cube[R2_W+RATIO_W-1:FRAC_W];
    end
    if (state == BK_TERMS) begin
      pos_sum <= POS_W'(r3) * COEF_CUBE + POS_W'(ratio) * COEF_LINEAR + OFFSET_TERM;
      neg_sum <= NEG_W'(r2) * COEF_SQUARE;
    end
    if (state == BK_CLAMP) begin
      scale_sat <= diff[POS_W-1:SCALE_SHIFT] >= SCALE_SAT;
      scaled    <= diff[SCALE_SHIFT +: SCALED_W];
    end
    if (state == BK_SCALE) begin
      conc <= scale_sat ? {CONC_W{1'b1}} : scale_prod[RECIP_SHIFT +: CONC_W];
    end
    if (load_out) begin
      out_conc <= conc;
      out_low  <= low_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/dust_pulse_occupancy_meter.sv
// Top level of the dust sensor low pulse occupancy meter.
//
//  Channel  Direction  Signals                              Transaction carries
//  s_       in         s_tvalid, s_tready, s_tdata[7:0]     one pin sample per tick
//  m_       out        m_tvalid, m_tready, m_tdata[55:0]    one result per window
//  cfg_     in         cfg_valid, cfg_ready, cfg_index,     one register write
//                      cfg_data
//
// Samples are taken one per cycle whenever the window queue has room.
// Each finished window holds the back end while it is popped, divided for the ratio at one bit
// per cycle, taken through the polynomial and scaling states, and loaded into the output register.
// Reset is synchronous and active high. Up to QUEUE_DEPTH windows wait in the queue; it fills
// under a stalled output or windows shorter than the back end's work on one window, and s_tready
// is low while it is full.
module dust_pulse_occupancy_meter #(
  parameter int QUEUE_DEPTH = 4  // finished windows buffered, 2 or more
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dpom_pkg::S_DATA_W-1:0]   s_tdata,   // [0] pin_level, [7:1] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dpom_pkg::M_DATA_W-1:0]   m_tdata,   // [23:0] concentration, [55:24] low_time
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpom_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dpom_pkg::*;

  logic [WIN_W-1:0]  window_ticks;
  logic [DIVR_W-1:0] ratio_divisor;

  win_push_t         push;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [LOW_W-1:0]  q_head;
  logic [CONC_W-1:0] out_conc;
  logic [LOW_W-1:0]  out_low;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks  <= WINDOW_TICKS_RESET;
      ratio_divisor <= RATIO_DIVISOR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WINDOW_TICKS) begin
        window_ticks <= cfg_data[WIN_W-1:0];
      end
      if (cfg_index == REG_RATIO_DIVISOR) begin
        ratio_divisor <= cfg_data[DIVR_W-1:0];
      end
    end
  end

  // The front counts low time sample by sample and hands each finished window
  // to the queue.
  dpom_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (s_tvalid),
    .pin_level    (s_tdata[0]),
    .window_ticks (window_ticks),
    .q_full       (q_full),
    .sample_ready (s_tready),
    .push         (push)
  );

  dpom_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  // The back turns a low count into a concentration and owns the output register.
  dpom_back u_back (
    .clk           (clk),
    .rst           (rst),
    .ratio_divisor (ratio_divisor),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_conc      (out_conc),
    .out_low       (out_low)
  );

  assign m_tdata = {out_low, out_conc};

endmodule

// File: rtl/core/dpom_checker.sv
// Port level checks of the dust meter, bound to the top level.
`include "assert_macros.svh"

module dpom_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dpom_pkg::M_DATA_W-1:0] m_tdata
);

  // A result waiting on the output keeps its value.
  `ASSERT_CLKD(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Reset empties the output register and the window queue.
  `ASSERT_CLK(a_out_reset, clk, rst |=> !m_tvalid, "result shown right after reset")
  `ASSERT_CLK(a_in_reset, clk, rst |=> s_tready, "samples refused right after reset")

  // A window with no low time gives only the constant term, 7/256.
  `ASSERT_CLKD(a_zero_low, clk, rst, m_tvalid && m_tdata[55:24] == 32'd0 |-> m_tdata[23:0] == 24'd7, "wrong concentration for zero low time")

endmodule

bind dust_pulse_occupancy_meter dpom_checker u_checker (.*);

// File: sim/dust_meter_checker.sv
// Scoreboard for the dust meter: it predicts each window result and compares it with the output.
`timescale 1ns / 1ps

module dust_meter_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [dpom_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [dpom_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dpom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpom_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              windows_done
);
  import dpom_pkg::*;

  typedef struct packed {
    logic [LOW_W-1:0]  low_time;
    logic [CONC_W-1:0] concentration;
  } window_result_t;

  logic [WIN_W-1:0]  window_len;
  logic [DIVR_W-1:0] divisor;
  logic              last_level;
  logic              timing_on;
  logic [LOW_W-1:0]  low_ticks;
  logic [LOW_W-1:0]  ticks_in_window;
  window_result_t    expected_q[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    windows_done = 0;
  end

  // Polynomial evaluated in units of 1/(10 * 65536); 51200 rescales the sum to Q16.8 over 20.
  function automatic logic [CONC_W-1:0] dust_concentration(input logic [LOW_W-1:0] lows,
                                                           input logic [DIVR_W-1:0] div);
    longint unsigned den, ratio, sq, cube, plus, minus, total, conc;
    den   = (div == '0) ? 64'd1 : 64'(div);
    ratio = (64'(lows) << FRAC_W) / den;
    if (ratio > 64'hFF_FFFF) ratio = 64'hFF_FFFF;
    sq    = (ratio * ratio) >> 16;
    cube  = (sq * ratio) >> 16;
    plus  = 11 * cube + 5200 * ratio + 406323;
    minus = 38 * sq;
    total = (plus > minus) ? plus - minus : 64'd0;
    conc  = total / 51200;
    return (conc > 64'hFF_FFFF) ? {CONC_W{1'b1}} : conc[CONC_W-1:0];
  endfunction

  task automatic take_sample(input logic level);
    logic [WIN_W-1:0] limit;
    window_result_t   res;
    limit = (window_len == '0) ? WIN_W'(1) : window_len;
    if (last_level && !level) timing_on = 1'b1;
    else if (!last_level && level) timing_on = 1'b0;
    last_level = level;
    if (timing_on && low_ticks != '1) low_ticks++;
    if (ticks_in_window != '1) ticks_in_window++;
    if (ticks_in_window >= limit) begin
      res.low_time      = low_ticks;
      res.concentration = dust_concentration(low_ticks, divisor);
      expected_q.push_back(res);
      low_ticks       = '0;
      ticks_in_window = '0;
    end
  endtask

  task automatic check_result(input logic [M_DATA_W-1:0] data);
    window_result_t want;
    if (expected_q.size() == 0) begin
      $error("result with no window pending: concentration %0d, low_time %0d",
             data[CONC_W-1:0], data[CONC_W +: LOW_W]);
      fail_count++;
    end else begin
      want = expected_q.pop_front();
      if (data[CONC_W-1:0] !== want.concentration) begin
        $error("concentration mismatch: expected %0d, got %0d",
               want.concentration, data[CONC_W-1:0]);
        fail_count++;
      end
      if (data[CONC_W +: LOW_W] !== want.low_time) begin
        $error("low_time mismatch: expected %0d, got %0d",
               want.low_time, data[CONC_W +: LOW_W]);
        fail_count++;
      end
      windows_done++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      window_len      = WINDOW_TICKS_RESET;
      divisor         = RATIO_DIVISOR_RESET;
      last_level      = 1'b1;
      timing_on       = 1'b0;
      low_ticks       = '0;
      ticks_in_window = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_TICKS:  window_len = cfg_data;
          REG_RATIO_DIVISOR: divisor    = cfg_data[DIVR_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) take_sample(s_tdata[0]);
      if (m_tvalid && m_tready) check_result(m_tdata);
    end
    pending = expected_q.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the dust meter regression: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import dpom_pkg::*;

  // The timeout is far above the slowest legal run: every sample closing a window, each
  // window passing through every back end state and the sink stalling at length.
  localparam int CYCLE_LIMIT    = 1_000_000;
  // Cycles let pass once nothing is expected, to cover the back end's latency.
  localparam int SETTLE_CYCLES  = 160;
  localparam int TARGET_SAMPLES = 400;
  localparam int TARGET_WINDOWS = 40;

  // Shapes of the pin waveform: realistic pulse trains, random noise, and long low pulses
  // that push the ratio and the concentration into saturation.
  typedef enum {WAVE_PULSE, WAVE_NOISE, WAVE_LONG_LOW} wave_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int windows_done;

  bit   tx_gaps      = 1'b0;  // sender inserts idle cycles between samples
  bit   rx_stalls    = 1'b0;  // sink drops m_tready at random
  int   stall_left   = 0;
  int   cycle_count  = 0;
  int   samples_sent = 0;
  int   windows_seen = 0;     // result count captured while the block is quiet
  logic cur_level    = 1'b1;  // last pin level sent, so pulse trains alternate

  always #2 clk = ~clk;

  dust_pulse_occupancy_meter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dust_meter_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .windows_done (windows_done)
  );

  // Idle stretches come from three ranges of growing length, picked 70, 25 and 5 percent of the time.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    else if (pick < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Result sink. Stalls land on every phase of the back end's work because their start
  // is random; with rx_stalls clear the sink simply stays ready.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
      m_tready   <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One sample transaction. The caller is always at a rising edge, so s_tvalid gets at
  // most one nonblocking assignment per time step and stays high between back-to-back
  // samples.
  task automatic send_word(input logic [S_DATA_W-1:0] word);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 99) < 25) ? idle_len() : 0;
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
    cur_level = word[0];
  endtask

  // A pin level; now and then the padding bits above it carry junk, which must be ignored.
  task automatic send_level(input logic level);
    logic [S_DATA_W-1:0] word;
    logic [31:0]         noise;
    noise = $urandom;
    word  = '0;
    if (noise[31:29] == 3'd0) word[S_DATA_W-1:1] = noise[S_DATA_W-2:0];
    word[0] = level;
    send_word(word);
  endtask

  // Register write transaction; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Waits until every predicted result has come back, then gives the back end time to
  // finish anything that would produce an unexpected result. Ends on a rising edge.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    windows_seen = windows_done;
    @(posedge clk);
  endtask

  task automatic send_wave(input wave_t wave, input int count);
    int   sent;
    int   run;
    logic level;
    sent = 0;
    while (sent < count) begin
      level = ~cur_level;
      case (wave)
        WAVE_NOISE: begin
          level = 1'($urandom_range(0, 1));
          run   = 1;
        end
        WAVE_LONG_LOW: begin
          run = level ? $urandom_range(1, 3) : $urandom_range(100, 250);
        end
        default: begin
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        end
      endcase
      for (int i = 0; i < run && sent < count; i++) begin
        send_level(level);
        sent++;
      end
    end
  endtask

  // One phase of the random part: program both registers while the block is idle, send a
  // waveform, and wait for every window result. The top byte of the divisor write carries
  // junk, since only the low 24 bits belong to the register.
  task automatic run_phase(input logic [WIN_W-1:0] win, input logic [DIVR_W-1:0] div,
                           input wave_t wave, input int count);
    logic [CFG_DATA_W-1:0] div_word;
    div_word              = $urandom;
    div_word[DIVR_W-1:0]  = div;
    tx_gaps               = ($urandom_range(0, 3) != 0);
    rx_stalls            <= ($urandom_range(0, 3) != 0);
    write_reg(REG_WINDOW_TICKS, win);
    write_reg(REG_RATIO_DIVISOR, div_word);
    cfg_valid <= 1'b0;
    send_wave(wave, count);
    drain();
  endtask

  initial begin
    logic [WIN_W-1:0]  win;
    logic [DIVR_W-1:0] div;
    wave_t             wave;
    int                count;
    int                phase;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. With the reset settings (a five million tick window) a short low pulse
    // produces no result, but the low time and the elapsed ticks carry on.
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'h00);
    send_word(8'h01);
    drain();

    // Window shortened below the ticks already elapsed: the next tick closes it. A zero
    // divisor acts as one, and writes to unknown indexes must change nothing.
    write_reg(REG_WINDOW_TICKS, 32'd3);
    write_reg(REG_RATIO_DIVISOR, 32'd0);
    write_reg(8'd2, 32'h0000_0001);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_word(8'hFE);
    drain();

    // A zero window acts as one: every tick ends a window, with both sides idling.
    tx_gaps    = 1'b1;
    rx_stalls <= 1'b1;
    write_reg(REG_WINDOW_TICKS, 32'd0);
    write_reg(REG_RATIO_DIVISOR, 32'd1);
    cfg_valid <= 1'b0;
    send_word(8'h00);
    send_word(8'h00);
    send_word(8'h01);
    send_word(8'h01);
    send_word(8'h00);
    send_word(8'h01);
    drain();

    // Largest window and largest divisor; then only the window is cut back to one tick, so
    // the low time gathered under the long window is reported with a ratio of zero.
    write_reg(REG_WINDOW_TICKS, 32'hFFFF_FFFF);
    write_reg(REG_RATIO_DIVISOR, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_word(8'h00);
    send_word(8'hAA);
    send_word(8'h54);
    drain();
    write_reg(REG_WINDOW_TICKS, 32'd1);
    cfg_valid <= 1'b0;
    send_word(8'h00);
    drain();

    // Random part. The second phase is always the long low pulse case so that the ratio
    // and the concentration both saturate at least once.
    phase = 0;
    while ((samples_sent < TARGET_SAMPLES || windows_seen < TARGET_WINDOWS) && phase < 100) begin
      if (phase == 1) begin
        win   = $urandom_range(290, 330);
        div   = DIVR_W'($urandom_range(0, 1));
        wave  = WAVE_LONG_LOW;
        count = int'(win) + $urandom_range(10, 30);
      end else begin
        case ($urandom_range(0, 9))
          0, 1:          win = $urandom_range(1, 4);
          2, 3, 4, 5, 6: win = $urandom_range(5, 60);
          default:       win = $urandom_range(61, 200);
        endcase
        case ($urandom_range(0, 4))
          0:       div = DIVR_W'($urandom_range(1, 16));
          1:       div = DIVR_W'($urandom_range(17, 4096));
          2:       div = DIVR_W'($urandom_range(1, 24'hFF_FFFF));
          3:       div = RATIO_DIVISOR_RESET;
          default: div = DIVR_W'($urandom_range(1, 200));
        endcase
        wave  = ($urandom_range(0, 99) < 80) ? WAVE_PULSE : WAVE_NOISE;
        count = $urandom_range(15, 45);
      end
      run_phase(win, div, wave, count);
      phase++;
    end

    // drain() has already waited out the back end after the last phase.
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
